// ----- rtl/dual_channel_moving_average_defines.svh -----
// ----------------------------------------------------------------------------
// dual_channel_moving_average_defines
// Assertion macros used by the moving-average filter controller.
// ----------------------------------------------------------------------------
`ifndef DUAL_CHANNEL_MOVING_AVERAGE_DEFINES_SVH
`define DUAL_CHANNEL_MOVING_AVERAGE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DCMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DCMA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dcma_pkg.sv -----
// ----------------------------------------------------------------------------
// dcma_pkg
// Shared types and constants of the dual-channel moving-average filter.
// ----------------------------------------------------------------------------
package dcma_pkg;

  // width of each filtered output field
  localparam int OUT_W = 12;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture samples, read the slot about to be overwritten
    logic update;    // update sums, write window, advance position, start divide
    logic step;      // one quotient bit per divider
    logic out_load;  // move quotients into the output register
  } cmd_t;

endpackage

// ----- rtl/dual_channel_moving_average.sv -----
// ----------------------------------------------------------------------------
// dual_channel_moving_average
// Two-channel moving-average filter with warm-up over a ring window.
// ----------------------------------------------------------------------------
// Each accepted transfer carries one light and one potentiometer sample; each
// produces one result with both windowed averages, the sum of the stored
// samples floor-divided by the fill count (which rises to WINDOW and holds).
// Each item runs through these steps before the next accept is possible:
// the accept and window read, the sum update and window write, the
// bit-serial dividers (one quotient bit per cycle, both channels together),
// and the output register load, which waits while an untaken result still
// holds the output register. The next item may be accepted while the result
// waits there.
// Window contents are treated as zero until the window first fills, so no
// clearing pass is needed after reset.
module dual_channel_moving_average #(
  parameter int WINDOW      = 8,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [SAMPLE_BITS-1:0]     in_raw_light,
  input  logic [SAMPLE_BITS-1:0]     in_raw_pot,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [dcma_pkg::OUT_W-1:0] out_filtered_light,
  output logic [dcma_pkg::OUT_W-1:0] out_filtered_pot
);

  dcma_pkg::cmd_t cmd;

  // sequencing and handshakes
  dcma_ctrl #(.SB(SAMPLE_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // window, sums and dividers
  dcma_dp #(.WINDOW(WINDOW), .SB(SAMPLE_BITS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .raw_light      (in_raw_light),
    .raw_pot        (in_raw_pot),
    .filtered_light (out_filtered_light),
    .filtered_pot   (out_filtered_pot)
  );

endmodule

// ----- rtl/dcma_div.sv -----
// ----------------------------------------------------------------------------
// dcma_div
// Bit-serial restoring divider: window sum by fill count, one bit per step.
// ----------------------------------------------------------------------------
module dcma_div #(
  parameter int SB    = 12,
  parameter int CNT_W = 4,
  parameter int SUM_W = 15
) (
  input  logic             clk,
  input  logic             start,
  input  logic             step,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic [SB-1:0]    quotient
);

  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [SB-1:0]    q_r, q_nxt;
  logic [CNT_W-1:0] dvs_r;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             ge;

  // trial subtract of the shifted partial remainder
  always_comb begin
    trial   = {rem_r, q_r[SB-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    q_nxt   = {q_r[SB-2:0], ge};
  end

  // the quotient fits in SB bits, so the upper sum bits seed the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= CNT_W'(dividend >> SB);
      q_r   <= dividend[SB-1:0];
      dvs_r <= divisor;
    end else if (step) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign quotient = q_r;

endmodule

// ----- rtl/dcma_dp.sv -----
// ----------------------------------------------------------------------------
// dcma_dp
// Datapath: sample window memory, running sums, fill count, dividers and
// output register.
// ----------------------------------------------------------------------------
module dcma_dp #(
  parameter int WINDOW = 8,
  parameter int SB     = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dcma_pkg::cmd_t            cmd,
  input  logic [SB-1:0]             raw_light,
  input  logic [SB-1:0]             raw_pot,
  output logic [dcma_pkg::OUT_W-1:0] filtered_light,
  output logic [dcma_pkg::OUT_W-1:0] filtered_pot
);

  localparam int ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = SB + $clog2(WINDOW);

  // window memory, both channels in one word: {light, pot}
  logic [2*SB-1:0]   mem [WINDOW];
  logic [2*SB-1:0]   rd_data_r;

  logic [SB-1:0]     light_r, pot_r;
  logic [ADDR_W-1:0] wpos_r, wpos_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [SUM_W-1:0]  light_sum_r, light_sum_nxt;
  logic [SUM_W-1:0]  pot_sum_r, pot_sum_nxt;
  logic              full;
  logic [SB-1:0]     old_light, old_pot;
  logic [SB-1:0]     q_light, q_pot;
  logic [dcma_pkg::OUT_W-1:0] out_light_r, out_pot_r;

  // before the window is full the slot being overwritten still reads as zero
  always_comb begin
    full          = (fill_r == CNT_W'(WINDOW));
    old_light     = full ? rd_data_r[2*SB-1:SB] : '0;
    old_pot       = full ? rd_data_r[SB-1:0] : '0;
    light_sum_nxt = light_sum_r - SUM_W'(old_light) + SUM_W'(light_r);
    pot_sum_nxt   = pot_sum_r - SUM_W'(old_pot) + SUM_W'(pot_r);
    fill_nxt      = full ? fill_r : fill_r + 1'b1;
    wpos_nxt      = (wpos_r == ADDR_W'(WINDOW - 1)) ? '0 : wpos_r + 1'b1;
  end

  // sample capture and slot read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      light_r   <= raw_light;
      pot_r     <= raw_pot;
      rd_data_r <= mem[wpos_r];
    end
  end

  // window write
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      mem[wpos_r] <= {light_r, pot_r};
    end
  end

  // position, fill count and running sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r      <= '0;
      fill_r      <= '0;
      light_sum_r <= '0;
      pot_sum_r   <= '0;
    end else if (cmd.update) begin
      wpos_r      <= wpos_nxt;
      fill_r      <= fill_nxt;
      light_sum_r <= light_sum_nxt;
      pot_sum_r   <= pot_sum_nxt;
    end
  end

  // one divider per channel, stepped together
  dcma_div #(.SB(SB), .CNT_W(CNT_W), .SUM_W(SUM_W)) u_div_light (
    .clk      (clk),
    .start    (cmd.update),
    .step     (cmd.step),
    .dividend (light_sum_nxt),
    .divisor  (fill_nxt),
    .quotient (q_light)
  );

  dcma_div #(.SB(SB), .CNT_W(CNT_W), .SUM_W(SUM_W)) u_div_pot (
    .clk      (clk),
    .start    (cmd.update),
    .step     (cmd.step),
    .dividend (pot_sum_nxt),
    .divisor  (fill_nxt),
    .quotient (q_pot)
  );

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_light_r <= dcma_pkg::OUT_W'(q_light);
      out_pot_r   <= dcma_pkg::OUT_W'(q_pot);
    end
  end

  assign filtered_light = out_light_r;
  assign filtered_pot   = out_pot_r;

endmodule

// ----- rtl/dcma_ctrl.sv -----
// ----------------------------------------------------------------------------
// dcma_ctrl
// Controller: handshakes, sequencing of one item and the divide step count.
// ----------------------------------------------------------------------------
`include "dual_channel_moving_average_defines.svh"

module dcma_ctrl #(
  parameter int SB = 12
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output dcma_pkg::cmd_t cmd
);

  localparam int STEP_W = $clog2(SB);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_UPD  = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        cnt_nxt    = STEP_W'(SB - 1);
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // checks
  `DCMA_ASSERT_NXT(a_accept_to_upd, clk, rst_n, in_valid && in_ready, state_r == S_UPD, "accepted transfer did not start an update")
  `DCMA_ASSERT_IMP(a_out_slot_free, clk, rst_n, cmd.out_load, !out_valid_r || out_ready, "result loaded over an untaken result")
  `DCMA_ASSERT_NXT(a_div_done, clk, rst_n, state_r == S_DIV && cnt_r == '0, state_r == S_FIN, "divide did not finish after its last step")

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual-channel moving-average filter.
// ----------------------------------------------------------------------------
// Sends light/pot sample pairs over the input handshake and keeps its own
// copy of the ring windows, running sums and fill count. From that copy it
// works out both floor averages for every sample pair it sends. Each output
// transfer is checked against the oldest pending average pair. The sequence
// is: warm-up from reset, window wrap-around at full scale, back-to-back
// traffic, a full drain pause, and then a long random run. Random gaps on the
// sender side and random stalls on the receiver side are used throughout, except in the back-to-back traffic.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int OUT_W       = dcma_pkg::OUT_W;
  localparam int WINDOW      = 8;
  localparam int SAMPLE_BITS = 12;
  localparam int SLOT_W      = $clog2(WINDOW);
  localparam int FILL_W      = $clog2(WINDOW + 1);
  localparam int SUM_W       = SAMPLE_BITS + SLOT_W;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SETTLE      = 2 * (SAMPLE_BITS + 3);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

  typedef struct packed {
    logic [OUT_W-1:0] light;
    logic [OUT_W-1:0] pot;
  } avg_pair_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [SAMPLE_BITS-1:0] in_raw_light;
  logic [SAMPLE_BITS-1:0] in_raw_pot;
  logic                   out_valid;
  logic                   out_ready;
  logic [OUT_W-1:0]       out_filtered_light;
  logic [OUT_W-1:0]       out_filtered_pot;

  // filter state as this bench tracks it
  logic [SAMPLE_BITS-1:0] light_hist [WINDOW];
  logic [SAMPLE_BITS-1:0] pot_hist   [WINDOW];
  logic [SLOT_W-1:0]      wr_slot;
  logic [FILL_W-1:0]      fill;
  logic [SUM_W-1:0]       light_total;
  logic [SUM_W-1:0]       pot_total;

  avg_pair_t   pending_avgs[$];
  int unsigned errors;
  int unsigned quiet_cycles;
  bit          no_idle;

  dual_channel_moving_average #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_raw_light       (in_raw_light),
    .in_raw_pot         (in_raw_pot),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_light (out_filtered_light),
    .out_filtered_pot   (out_filtered_pot)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // window state after reset
  function automatic void clear_windows();
    for (int k = 0; k < WINDOW; k++) begin
      light_hist[k] = '0;
      pot_hist[k]   = '0;
    end
    wr_slot     = '0;
    fill        = '0;
    light_total = '0;
    pot_total   = '0;
  endfunction

  // store one sample pair, return both floor averages
  function automatic avg_pair_t window_average(input logic [SAMPLE_BITS-1:0] light,
                                               input logic [SAMPLE_BITS-1:0] pot);
    avg_pair_t avg;
    light_total       = light_total - light_hist[wr_slot] + light;
    pot_total         = pot_total - pot_hist[wr_slot] + pot;
    light_hist[wr_slot] = light;
    pot_hist[wr_slot]   = pot;
    wr_slot = (wr_slot == SLOT_W'(WINDOW - 1)) ? '0 : wr_slot + 1'b1;
    if (fill < WINDOW) fill = fill + 1'b1;
    avg.light = OUT_W'(light_total / fill);
    avg.pot   = OUT_W'(pot_total / fill);
    return avg;
  endfunction

  // drive one sample pair and wait for its transfer
  task automatic send_samples(input logic [SAMPLE_BITS-1:0] light,
                              input logic [SAMPLE_BITS-1:0] pot);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_raw_light <= light;
    in_raw_pot   <= pot;
    do @(posedge clk); while (!in_ready);
    pending_avgs.push_back(window_average(light, pot));
  endtask

  // receiver side: random stalls unless idling is off
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (no_idle) begin
        out_ready  <= 1'b1;
        stall_left = 0;
      end else if (stall_left != 0) begin
        out_ready  <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < 30) stall_left = idle_len();
      end
    end
  end

  // compare each output transfer with the oldest pending average pair
  always @(posedge clk) begin
    avg_pair_t exp_avg;
    if (rst_n && out_valid && out_ready) begin
      if (pending_avgs.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got light %0d pot %0d",
                 $time, out_filtered_light, out_filtered_pot);
      end else begin
        exp_avg = pending_avgs.pop_front();
        if (out_filtered_light !== exp_avg.light) begin
          errors++;
          $display("%0t: filtered_light mismatch, expected %0d, got %0d",
                   $time, exp_avg.light, out_filtered_light);
        end
        if (out_filtered_pot !== exp_avg.pot) begin
          errors++;
          $display("%0t: filtered_pot mismatch, expected %0d, got %0d",
                   $time, exp_avg.pot, out_filtered_pot);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // warm-up: fill count 1..8 with extremes and floor rounding
  task automatic test_warmup();
    send_samples(SAMPLE_MAX, '0);
    send_samples('0, SAMPLE_MAX);
    send_samples(12'd1, 12'd4094);
    send_samples(SAMPLE_MAX, '0);
    send_samples(12'd2048, 12'd2047);
    send_samples(12'd7, SAMPLE_MAX);
    send_samples(SAMPLE_MAX, 12'd1);
    send_samples(12'd100, 12'd2730);
  endtask

  // full window: oldest entry replaced, sums at full scale
  task automatic test_window_wrap();
    repeat (WINDOW) send_samples(SAMPLE_MAX, SAMPLE_MAX);
    send_samples('0, 12'hAAA);
    send_samples('0, 12'h555);
    send_samples(12'hAAA, '0);
    send_samples(12'h555, SAMPLE_MAX);
  endtask

  // back-to-back transfers on both sides
  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (40) send_samples(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
    no_idle = 1'b0;
  endtask

  // sender holds off until every pending result has come back
  task automatic test_drain_pause();
    repeat (12) send_samples(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (8) send_samples(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
  endtask

  // random run: uniform, extremes, slowly drifting levels, bit patterns
  task automatic test_random_samples(input int unsigned count);
    logic [SAMPLE_BITS-1:0] light, pot, level_l, level_p;
    int unsigned kind;
    level_l = SAMPLE_BITS'($urandom);
    level_p = SAMPLE_BITS'($urandom);
    repeat (count) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        light = SAMPLE_BITS'($urandom);
        pot   = SAMPLE_BITS'($urandom);
      end else if (kind < 70) begin
        light = $urandom_range(0, 1) ? SAMPLE_MAX : '0;
        pot   = $urandom_range(0, 1) ? SAMPLE_MAX : '0;
      end else if (kind < 90) begin
        level_l = level_l + SAMPLE_BITS'($urandom_range(0, 64)) - 12'd32;
        level_p = level_p + SAMPLE_BITS'($urandom_range(0, 64)) - 12'd32;
        light   = level_l + SAMPLE_BITS'($urandom_range(0, 7));
        pot     = level_p + SAMPLE_BITS'($urandom_range(0, 7));
      end else begin
        light = SAMPLE_BITS'(1) << $urandom_range(0, SAMPLE_BITS - 1);
        pot   = ~(SAMPLE_BITS'(1) << $urandom_range(0, SAMPLE_BITS - 1));
      end
      send_samples(light, pot);
    end
  endtask

  // main sequence
  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_raw_light <= '0;
    in_raw_pot   <= '0;
    no_idle      = 1'b0;
    clear_windows();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_warmup();
    test_window_wrap();
    test_back_to_back();
    test_drain_pause();
    test_random_samples(540);

    // let the last results come out, then watch for strays
    in_valid <= 1'b0;
    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
